// ----- design/telemetry_delta_packetizer_macros.svh -----
// assertion macros shared by the packetizer modules
// expects clk and rst_n in the scope of every use
`ifndef TELEMETRY_DELTA_PACKETIZER_MACROS_SVH
`define TELEMETRY_DELTA_PACKETIZER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tdp_pkg.sv -----
// shared types and constants of the telemetry delta packetizer
// no dependencies
package tdp_pkg;

  // widest snapshot the packet format can describe (one mask bit per byte)
  localparam int MAX_FIELDS = 8;

  typedef struct packed {
    logic [7:0] full_type;
    logic [7:0] diff_type;
    logic [7:0] version;
    logic [7:0] interval;
  } tdp_cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [3:0] status_flags;
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic [7:0] turret_rotation;
    logic [7:0] turret_elevation;
  } tdp_snap_t;

  // one packet as handed from the builder to the serializer
  typedef struct packed {
    logic                             full;
    logic [7:0]                       type_byte;
    logic [7:0]                       version;
    logic [MAX_FIELDS-1:0]            mask;
    logic [MAX_FIELDS-1:0][7:0]       data;
  } tdp_pkt_t;

endpackage

// ----- design/tdp_cfg_regs.sv -----
// apb-style configuration registers of the packetizer
// depends on tdp_pkg
module tdp_cfg_regs
  import tdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output tdp_cfg_t    cfg
);

  localparam logic [1:0] REG_FULL_TYPE = 2'd0;
  localparam logic [1:0] REG_DIFF_TYPE = 2'd1;
  localparam logic [1:0] REG_VERSION   = 2'd2;
  localparam logic [1:0] REG_INTERVAL  = 2'd3;

  tdp_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_type <= 8'd1;
      cfg_r.diff_type <= 8'd2;
      cfg_r.version   <= 8'd2;
      cfg_r.interval  <= 8'd10;
    end else if (wr_en) begin
      case (idx)
        REG_FULL_TYPE: cfg_r.full_type <= pwdata[7:0];
        REG_DIFF_TYPE: cfg_r.diff_type <= pwdata[7:0];
        REG_VERSION:   cfg_r.version   <= pwdata[7:0];
        REG_INTERVAL:  cfg_r.interval  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FULL_TYPE: prdata = {24'd0, cfg_r.full_type};
      REG_DIFF_TYPE: prdata = {24'd0, cfg_r.diff_type};
      REG_VERSION:   prdata = {24'd0, cfg_r.version};
      REG_INTERVAL:  prdata = {24'd0, cfg_r.interval};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/tdp_builder.sv -----
// packet decision and change mask, holds the stored snapshot and tick counter
// depends on tdp_pkg and the assertion macro header
`include "telemetry_delta_packetizer_macros.svh"
module tdp_builder
  import tdp_pkg::*;
#(
  parameter int NUM_FIELDS = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  tdp_snap_t snap,
  input  tdp_cfg_t  cfg,
  output tdp_pkt_t  pkt
);

  logic [7:0] prev_r [NUM_FIELDS];
  logic       have_prev_r;
  logic [7:0] tick_r;
  logic [7:0] tick_nxt;
  logic [7:0] tick_inc;
  logic       full;

  logic [MAX_FIELDS-1:0][7:0] src;
  logic [MAX_FIELDS-1:0]      diff_mask;
  logic [MAX_FIELDS-1:0]      all_mask;

  always_comb begin
    src    = '0;
    src[0] = {4'd0, snap.status_flags};
    src[1] = snap.left_drive;
    src[2] = snap.right_drive;
    src[3] = snap.turret_rotation;
    src[4] = snap.turret_elevation;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_FIELDS; g++) begin : g_field
      if (g < NUM_FIELDS) begin : g_used
        assign diff_mask[g] = (prev_r[g] != src[g]);
        assign all_mask[g]  = 1'b1;
        assign pkt.data[g]  = src[g];
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            prev_r[g] <= 8'd0;
          end else if (fire) begin
            prev_r[g] <= src[g];
          end
        end
      end else begin : g_unused
        assign diff_mask[g] = 1'b0;
        assign all_mask[g]  = 1'b0;
        assign pkt.data[g]  = 8'd0;
      end
    end
  endgenerate

  assign tick_inc = tick_r + 8'd1;
  assign full     = snap.cmd || !have_prev_r || (tick_inc >= cfg.interval);
  assign tick_nxt = full ? 8'd0 : tick_inc;

  assign pkt.full      = full;
  assign pkt.type_byte = full ? cfg.full_type : cfg.diff_type;
  assign pkt.version   = cfg.version;
  assign pkt.mask      = full ? all_mask : diff_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      tick_r      <= 8'd0;
    end else if (fire) begin
      have_prev_r <= 1'b1;
      tick_r      <= tick_nxt;
    end
  end

  `TDP_ASSERT_NEXT(a_full_clears_tick, fire && full, tick_r == 8'd0, "tick not cleared")
  `TDP_ASSERT_NEXT(a_prev_after_fire, fire, have_prev_r, "snapshot not marked stored")
  `TDP_ASSERT_NOW(a_diff_needs_prev, fire && !full, have_prev_r && !snap.cmd,
                  "diff packet without stored snapshot")

endmodule

// ----- design/tdp_serializer.sv -----
// packet register and byte-wide output sequencer
// depends on tdp_pkg and the assertion macro header
`include "telemetry_delta_packetizer_macros.svh"
module tdp_serializer
  import tdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  tdp_pkt_t   pkt,
  output logic       load_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_VER  = 2'd1;
  localparam logic [1:0] PH_MASK = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  localparam int SW = $clog2(MAX_FIELDS);

  tdp_pkt_t              pkt_r;
  logic                  busy_r;
  logic [1:0]            phase_r;
  logic [1:0]            phase_nxt;
  logic [MAX_FIELDS-1:0] rem_r;
  logic [MAX_FIELDS-1:0] rem_drop;
  logic [SW-1:0]         sel;
  logic                  fire;

  // lowest pending field
  always_comb begin
    sel = '0;
    for (int i = MAX_FIELDS - 1; i >= 0; i--) begin
      if (rem_r[i]) sel = SW'(i);
    end
  end

  assign rem_drop = rem_r & (rem_r - MAX_FIELDS'(1));

  always_comb begin
    case (phase_r)
      PH_TYPE: begin
        out_byte  = pkt_r.type_byte;
        out_last  = 1'b0;
        phase_nxt = PH_VER;
      end
      PH_VER: begin
        out_byte  = pkt_r.version;
        out_last  = 1'b0;
        phase_nxt = pkt_r.full ? PH_DATA : PH_MASK;
      end
      PH_MASK: begin
        out_byte  = 8'(pkt_r.mask);
        out_last  = (rem_r == '0);
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        out_byte  = pkt_r.data[sel];
        out_last  = (rem_drop == '0);
        phase_nxt = PH_DATA;
      end
      default: begin
        out_byte  = 8'd0;
        out_last  = 1'b0;
        phase_nxt = PH_TYPE;
      end
    endcase
  end

  assign out_valid = busy_r;
  assign fire      = busy_r && out_ready;
  assign load_ok   = !busy_r || (fire && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_TYPE;
    end else if (load) begin
      busy_r  <= 1'b1;
      phase_r <= PH_TYPE;
    end else if (fire) begin
      busy_r  <= !out_last;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt_r <= pkt;
      rem_r <= pkt.mask;
    end else if (fire && phase_r == PH_DATA) begin
      rem_r <= rem_drop;
    end
  end

  `TDP_ASSERT_NOW(a_data_pending, busy_r && phase_r == PH_DATA, rem_r != '0,
                  "data phase with no field left")
  `TDP_ASSERT_NEXT(a_done_goes_idle, fire && out_last && !load, !busy_r,
                   "sequencer busy after last byte")
  `TDP_ASSERT_NEXT(a_load_starts_type, load, busy_r && phase_r == PH_TYPE,
                   "packet did not start at type byte")

endmodule

// ----- design/telemetry_delta_packetizer.sv -----
// Telemetry delta packetizer. Each input item is a five-byte snapshot (status
// flags in byte 0, then left drive, right drive, turret rotation, turret
// elevation) with a command bit on in_tuser: 0 is a periodic tick, 1 forces a
// full snapshot. Each item produces one packet on the byte-wide output
// stream, out_tlast marking its final byte. A full packet is type, version and
// all NUM_FIELDS bytes; a diff packet is type, version, a changed mask and
// only the changed bytes in index order. A full packet is sent on a forced
// snapshot, when nothing is stored yet, or when the tick counter reaches
// full_interval. Timing: an item is taken into the input register, then the
// packet is decided and loaded into the output sequencer once that is free or
// sending its last byte; bytes leave one per cycle while out_tready is high.
// The byte-wide output sequencer sets the sustained rate: NUM_FIELDS + 2 bytes
// per full packet (7 at the default) and 3 + changed-byte count per diff packet
// (3 to 8), while the following item already waits in the input register.
// Configuration registers sit at byte addresses 0 (full type), 4 (diff type),
// 8 (version) and 12 (full interval); write them only while the block is idle.
// depends on tdp_pkg, tdp_cfg_regs, tdp_builder, tdp_serializer
module telemetry_delta_packetizer
  import tdp_pkg::*;
#(
  parameter int NUM_FIELDS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: status_flags[3:0], left_drive[11:4], right_drive[19:12],
  // turret_rotation[27:20], turret_elevation[35:28], zero fill [39:36]
  input  logic [39:0] in_tdata,
  // tuser: cmd
  input  logic        in_tuser,
  // packet byte stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: packet_byte
  output logic [7:0]  out_tdata,
  // tlast: last_byte
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tdp_cfg_t  cfg;
  tdp_snap_t snap_r;
  tdp_pkt_t  pkt;
  logic      in_v_r;
  logic      load_ok;
  logic      build_fire;

  tdp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // the held item moves on as soon as the sequencer is free or finishing
  assign build_fire = in_v_r && load_ok;
  // the input register refills in the same cycle it is emptied
  assign in_tready  = !in_v_r || build_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      snap_r.cmd              <= in_tuser;
      snap_r.status_flags     <= in_tdata[3:0];
      snap_r.left_drive       <= in_tdata[11:4];
      snap_r.right_drive      <= in_tdata[19:12];
      snap_r.turret_rotation  <= in_tdata[27:20];
      snap_r.turret_elevation <= in_tdata[35:28];
    end
  end

  tdp_builder #(
    .NUM_FIELDS (NUM_FIELDS)
  ) u_builder (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (build_fire),
    .snap  (snap_r),
    .cfg   (cfg),
    .pkt   (pkt)
  );

  tdp_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (build_fire),
    .pkt       (pkt),
    .load_ok   (load_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ----- verif/telemetry_delta_packetizer_tb.sv -----
// self-checking testbench for telemetry_delta_packetizer: snapshots in, packet bytes out
// depends on tdp_pkg and the telemetry_delta_packetizer rtl
`timescale 1ns / 1ps

module telemetry_delta_packetizer_tb
  import tdp_pkg::*;
();

  // snapshot bytes carried by the block at its default size
  localparam int SNAP_BYTES = 5;
  // cycles to let pass once the last packet byte is in
  localparam int SETTLE_CYCLES = 12;

  // register byte addresses
  localparam logic [3:0] ADDR_FULL_TYPE = 4'd0;
  localparam logic [3:0] ADDR_DIFF_TYPE = 4'd4;
  localparam logic [3:0] ADDR_VERSION   = 4'd8;
  localparam logic [3:0] ADDR_INTERVAL  = 4'd12;

  // command on in_tuser
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_FORCE = 1'b1;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  telemetry_delta_packetizer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // snapshots waiting for the driver, and packet bytes still owed by the block
  tdp_snap_t snapshots_to_send[$];
  pkt_byte_t packet_bytes_due[$];

  // shadow of the block: registers, stored snapshot, tick counter
  tdp_cfg_t   shadow_cfg;
  logic [7:0] stored_snap [SNAP_BYTES];
  logic       have_stored;
  logic [7:0] tick_cnt;

  // idle rates in percent, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int        err_count = 0;
  logic      drain_hold = 1'b0;
  tdp_snap_t cur_item;
  tdp_snap_t last_gen;

  task automatic flag_error(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // work out the packet one accepted snapshot must produce, and advance the shadow
  task automatic encode_snapshot(input tdp_snap_t s);
    logic [7:0] snap [SNAP_BYTES];
    logic [7:0] pkt [SNAP_BYTES + 3];
    logic [7:0] mask;
    logic       send_full;
    int         n;
    pkt_byte_t  b;
    snap[0] = {4'b0, s.status_flags};
    snap[1] = s.left_drive;
    snap[2] = s.right_drive;
    snap[3] = s.turret_rotation;
    snap[4] = s.turret_elevation;
    n = 0;
    mask = '0;
    // forced snapshot or nothing stored yet: full packet, counter restarts
    if (s.cmd == CMD_FORCE || !have_stored) begin
      tick_cnt = '0;
      send_full = 1'b1;
    end else begin
      tick_cnt = tick_cnt + 8'd1;
      // also covers an interval of zero and an interval lowered under the count
      if (tick_cnt >= shadow_cfg.interval) begin
        tick_cnt = '0;
        send_full = 1'b1;
      end else begin
        send_full = 1'b0;
      end
    end
    if (send_full) begin
      pkt[n] = shadow_cfg.full_type;
      n = n + 1;
      pkt[n] = shadow_cfg.version;
      n = n + 1;
      for (int i = 0; i < SNAP_BYTES; i++) begin
        pkt[n] = snap[i];
        n = n + 1;
      end
    end else begin
      for (int i = 0; i < SNAP_BYTES; i++)
        if (stored_snap[i] != snap[i]) mask[i] = 1'b1;
      pkt[n] = shadow_cfg.diff_type;
      n = n + 1;
      pkt[n] = shadow_cfg.version;
      n = n + 1;
      pkt[n] = mask;   // an unchanged snapshot still sends a zero mask
      n = n + 1;
      for (int i = 0; i < SNAP_BYTES; i++) begin
        if (mask[i]) begin
          pkt[n] = snap[i];
          n = n + 1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      b.data = pkt[i];
      b.last = (i == n - 1);
      packet_bytes_due.push_back(b);
    end
    for (int i = 0; i < SNAP_BYTES; i++) stored_snap[i] = snap[i];
    have_stored = 1'b1;
  endtask

  // driver: presents queued snapshots, predicts on every accepted item
  always @(posedge clk) begin : drive_items
    tdp_snap_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        encode_snapshot(cur_item);
        // now and then hold the sender until the block has emptied out
        if ($urandom_range(49) == 0) drain_hold = 1'b1;
      end else if (drain_hold && packet_bytes_due.size() == 0) begin
        drain_hold = 1'b0;
      end
      if (!in_tvalid || in_tready) begin
        if (snapshots_to_send.size() != 0 && !drain_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = snapshots_to_send.pop_front();
          cur_item = nxt;
          in_tvalid <= 1'b1;
          // tdata from bit 0: flags, left, right, rotation, elevation, zero fill
          in_tdata <= {4'b0, nxt.turret_elevation, nxt.turret_rotation,
                       nxt.right_drive, nxt.left_drive, nxt.status_flags};
          in_tuser <= nxt.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted packet byte against the oldest one owed
  always @(posedge clk) begin : watch_bytes
    pkt_byte_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (packet_bytes_due.size() == 0) begin
          flag_error($sformatf("byte %02h last %0b with nothing owed", out_tdata, out_tlast));
        end else begin
          want = packet_bytes_due.pop_front();
          if (out_tdata !== want.data)
            flag_error($sformatf("packet byte %02h, want %02h", out_tdata, want.data));
          if (out_tlast !== want.last)
            flag_error($sformatf("last mark %b on byte %02h, want %b",
                                 out_tlast, out_tdata, want.last));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one apb transfer: setup cycle, then access cycle (pready is always high)
  task automatic apb_xfer(input logic wr, input logic [3:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // write a register, mirror it in the shadow, read it back
  task automatic set_reg(input logic [3:0] addr, input logic [7:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, addr, {24'b0, val}, rd);
    case (addr)
      ADDR_FULL_TYPE: shadow_cfg.full_type = val;
      ADDR_DIFF_TYPE: shadow_cfg.diff_type = val;
      ADDR_VERSION:   shadow_cfg.version   = val;
      ADDR_INTERVAL:  shadow_cfg.interval  = val;
      default: ;
    endcase
    apb_xfer(1'b0, addr, '0, rd);
    if (rd !== {24'b0, val})
      flag_error($sformatf("register at %0d reads %08h, want %08h", addr, rd, {24'b0, val}));
  endtask

  // block idle: nothing queued, nothing presented, nothing owed
  task automatic wait_idle();
    while (snapshots_to_send.size() != 0 || in_tvalid || packet_bytes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic tdp_snap_t snapshot(input logic c, input logic [3:0] f,
                                         input logic [7:0] l, r, rot, el);
    tdp_snap_t s;
    s.cmd = c;
    s.status_flags = f;
    s.left_drive = l;
    s.right_drive = r;
    s.turret_rotation = rot;
    s.turret_elevation = el;
    return s;
  endfunction

  // mostly slowly drifting telemetry: a few bytes move per tick, some forced
  // snapshots, and now and then a snapshot of pure noise
  task automatic queue_random_items(input int count);
    tdp_snap_t s;
    for (int k = 0; k < count; k++) begin
      s = last_gen;
      s.cmd = ($urandom_range(9) == 0) ? CMD_FORCE : CMD_TICK;
      if ($urandom_range(14) == 0) begin
        s = snapshot(s.cmd, 4'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
      end else begin
        if ($urandom_range(99) < 30) s.status_flags = 4'($urandom);
        if ($urandom_range(99) < 30) s.left_drive = 8'($urandom);
        if ($urandom_range(99) < 30) s.right_drive = 8'($urandom);
        if ($urandom_range(99) < 30) s.turret_rotation = 8'($urandom);
        if ($urandom_range(99) < 30) s.turret_elevation = 8'($urandom);
      end
      snapshots_to_send.push_back(s);
      last_gen = s;
    end
  endtask

  task automatic random_cfg();
    set_reg(ADDR_FULL_TYPE, 8'($urandom));
    set_reg(ADDR_DIFF_TYPE, 8'($urandom));
    set_reg(ADDR_VERSION, 8'($urandom));
    case ($urandom_range(3))
      0:       set_reg(ADDR_INTERVAL, 8'd1);
      1:       set_reg(ADDR_INTERVAL, 8'd255);
      default: set_reg(ADDR_INTERVAL, 8'($urandom_range(2, 12)));
    endcase
  endtask

  initial begin
    shadow_cfg.full_type = 8'd1;
    shadow_cfg.diff_type = 8'd2;
    shadow_cfg.version   = 8'd2;
    shadow_cfg.interval  = 8'd10;
    for (int i = 0; i < SNAP_BYTES; i++) stored_snap[i] = '0;
    have_stored = 1'b0;
    tick_cnt = '0;
    last_gen = snapshot(CMD_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 78;

    // reset config: first tick with nothing stored goes out full, then diffs
    // of no change, of every byte, and of single and paired bytes around a forced snapshot
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'hf, 8'hff, 8'hff, 8'hff, 8'hff));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'hf, 8'hff, 8'h00, 8'hff, 8'hff));
    snapshots_to_send.push_back(snapshot(CMD_FORCE, 4'h5, 8'h12, 8'h34, 8'h56, 8'h78));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'ha, 8'h12, 8'h34, 8'h56, 8'h79));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'ha, 8'h13, 8'h34, 8'h57, 8'h79));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_idle();

    // extreme register values, longest interval: tick count runs up with diffs
    set_reg(ADDR_FULL_TYPE, 8'hff);
    set_reg(ADDR_DIFF_TYPE, 8'h00);
    set_reg(ADDR_VERSION, 8'hff);
    set_reg(ADDR_INTERVAL, 8'd255);
    for (int k = 0; k < 8; k++)
      snapshots_to_send.push_back(snapshot(CMD_TICK, 4'(k), 8'(k * 37), 8'h00,
                                           8'(8'hff - k), (k[0] ? 8'h80 : 8'h7f)));
    wait_idle();

    // interval lowered under the running count: next tick is full
    set_reg(ADDR_FULL_TYPE, 8'h00);
    set_reg(ADDR_DIFF_TYPE, 8'hff);
    set_reg(ADDR_VERSION, 8'h00);
    set_reg(ADDR_INTERVAL, 8'd3);
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'h3, 8'h01, 8'h02, 8'h03, 8'h04));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'h3, 8'h01, 8'h02, 8'h03, 8'h05));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'hc, 8'h01, 8'h02, 8'h03, 8'h05));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'hc, 8'hfe, 8'h02, 8'h03, 8'h05));
    wait_idle();

    // interval of zero: every tick is full
    set_reg(ADDR_INTERVAL, 8'd0);
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'h1, 8'h10, 8'h20, 8'h30, 8'h40));
    snapshots_to_send.push_back(snapshot(CMD_TICK, 4'h1, 8'h10, 8'h21, 8'h30, 8'h40));
    wait_idle();

    // random phases: receiver-heavy idling, sender-heavy idling, then none
    random_cfg();
    queue_random_items(140);
    wait_idle();

    send_idle_pct = 78;
    recv_idle_pct = 31;
    random_cfg();
    queue_random_items(140);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_cfg();
    queue_random_items(140);
    wait_idle();

    if (err_count == 0) begin
      $display("telemetry_delta_packetizer_tb: done, clean");
    end else begin
      $display("telemetry_delta_packetizer_tb: done, errors");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #1000000;
    $display("telemetry_delta_packetizer_tb: done, errors");
    $finish;
  end

endmodule
